FILE: hdl/recursive_mutex_with_fifo_handoff_macros.svh
// Assertion macros shared by the mutex unit modules.
`ifndef RECURSIVE_MUTEX_WITH_FIFO_HANDOFF_MACROS_SVH
`define RECURSIVE_MUTEX_WITH_FIFO_HANDOFF_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMWF_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rmwf check failed");

// Next-cycle implication, disabled during reset.
`define RMWF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rmwf check failed");

`endif

FILE: hdl/rmwf_pkg.sv
// Types, codes and default sizes for the mutex unit.
package rmwf_pkg;

  localparam int unsigned DEF_MAX_WAITERS    = 16;
  localparam int unsigned DEF_THREAD_ID_BITS = 8;
  localparam int unsigned DEF_COUNT_BITS     = 16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // request kinds
  localparam logic [1:0] FUNC_LOCK     = 2'd0;
  localparam logic [1:0] FUNC_TRY_LOCK = 2'd1;
  localparam logic [1:0] FUNC_UNLOCK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BLOCKED   = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_NOT_OWNER = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // register word index (paddr[2])
  localparam logic REG_RECURSIVE_MODE = 1'b0;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        owner_valid;
    logic [7:0]  owner_thread;
    logic [15:0] hold_count;
    logic        wake_valid;
    logic [7:0]  wake_thread;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture request, start head read
    logic exec;  // apply request, register result
  } rmwf_cmd_t;

endpackage

FILE: hdl/rmwf_ctrl.sv
// Sequencer for the mutex unit: accept, execute, report.
`include "recursive_mutex_with_fifo_handoff_macros.svh"

module rmwf_ctrl
  import rmwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output rmwf_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = start && !busy;
    cmd.exec = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

  `RMWF_ASSERT_NOW(a_busy_in_exec, clk, rst, state == S_EXEC, busy)
  `RMWF_ASSERT_NEXT(a_load_to_exec, clk, rst, cmd.load, state == S_EXEC)
  `RMWF_ASSERT_NEXT(a_exec_to_done, clk, rst, cmd.exec, done && !busy)

endmodule

FILE: hdl/rmwf_dp.sv
// Mutex state, wait queue memory and result register.
`include "recursive_mutex_with_fifo_handoff_macros.svh"

module rmwf_dp
  import rmwf_pkg::*;
#(
  parameter int unsigned MAX_WAITERS    = DEF_MAX_WAITERS,
  parameter int unsigned THREAD_ID_BITS = DEF_THREAD_ID_BITS,
  parameter int unsigned COUNT_BITS     = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  rmwf_cmd_t cmd,
  input  req_t      req,
  input  logic      recursive_mode,
  output rsp_t      result
);

  localparam int unsigned PTR_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_WAITERS + 1);
  localparam logic [PTR_W-1:0]      LAST_SLOT = PTR_W'(MAX_WAITERS - 1);
  localparam logic [FILL_W-1:0]     FULL_FILL = FILL_W'(MAX_WAITERS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // captured request
  logic [1:0]                func;
  logic [THREAD_ID_BITS-1:0] tid;

  // mutex state
  logic                      held, held_next;
  logic [THREAD_ID_BITS-1:0] owner, owner_next;
  logic [COUNT_BITS-1:0]     count, count_next;
  logic [PTR_W-1:0]          head, head_next;
  logic [PTR_W-1:0]          tail, tail_next;
  logic [FILL_W-1:0]         fill, fill_next;

  // wait queue
  logic [THREAD_ID_BITS-1:0] wait_mem [MAX_WAITERS];
  logic [THREAD_ID_BITS-1:0] head_id;
  logic                      enq;

  logic [2:0]            status;
  logic                  wake;
  logic [COUNT_BITS-1:0] cnt_dec;

  always_comb begin
    held_next  = held;
    owner_next = owner;
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    status     = ST_OK;
    wake       = 1'b0;
    enq        = 1'b0;
    cnt_dec    = (count != '0) ? count - COUNT_ONE : count;
    case (func)
      FUNC_LOCK: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = tid;
          count_next = COUNT_ONE;
        end else if (owner == tid) begin
          if (recursive_mode && (count != COUNT_MAX)) begin
            count_next = count + COUNT_ONE;
          end
        end else if (fill == FULL_FILL) begin
          status = ST_FULL;
        end else begin
          enq       = 1'b1;
          tail_next = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
          fill_next = fill + FILL_W'(1);
          status    = ST_BLOCKED;
        end
      end
      FUNC_TRY_LOCK: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = tid;
          count_next = COUNT_ONE;
        end else begin
          status = ST_REFUSED;
        end
      end
      FUNC_UNLOCK: begin
        if (!held || (owner != tid)) begin
          status = ST_NOT_OWNER;
        end else begin
          count_next = cnt_dec;
          if (!(recursive_mode && (cnt_dec != '0))) begin
            if (fill == '0) begin
              held_next  = 1'b0;
              owner_next = '0;
              count_next = '0;
            end else begin
              wake       = 1'b1;
              owner_next = head_id;
              count_next = COUNT_ONE;
              head_next  = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
              fill_next  = fill - FILL_W'(1);
            end
          end
        end
      end
      default: begin
        status = ST_OK;  // unused code: no effect
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= req.func;
      tid  <= THREAD_ID_BITS'(req.thread_id);
    end
  end

  // queue memory: head read is registered every cycle, so it is ready in exec
  always_ff @(posedge clk) begin
    head_id <= wait_mem[head];
    if (cmd.exec && enq) begin
      wait_mem[tail] <= tid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      count <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (cmd.exec) begin
      held  <= held_next;
      owner <= owner_next;
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.status       <= status;
      result.owner_valid  <= held_next;
      result.owner_thread <= held_next ? 8'(owner_next) : 8'd0;
      result.hold_count   <= held_next ? 16'(count_next) : 16'd0;
      result.wake_valid   <= wake;
      result.wake_thread  <= wake ? 8'(head_id) : 8'd0;
    end
  end

  `RMWF_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FULL_FILL)
  `RMWF_ASSERT_NOW(a_waiters_need_owner, clk, rst, fill != '0, held)
  `RMWF_ASSERT_NOW(a_free_is_clean, clk, rst, !held, (owner == '0) && (count == '0))

endmodule

FILE: hdl/recursive_mutex_with_fifo_handoff.sv
// Top level of the recursive mutex unit with FIFO wait-queue handoff.
//
//  channel   handshake                       payload
//  --------  ------------------------------  --------------------------------
//  request   start high, busy low            req    (func, thread_id)
//  result    done high for one cycle         result (status, owner, count, wake)
//  config    psel & penable & pwrite          pwdata[0] -> recursive_mode
//
//  A transaction is accepted, then executed; done rises the cycle after
//  execute, which is also the next cycle a request can be accepted.
//  The separate execute step comes from the registered read of the wait-queue head.
//  Synchronous active-high rst frees the mutex, empties the queue and clears
//  recursive_mode; queue memory contents are not cleared.
//  The receiver has no stall; each result is valid only in its done cycle.
module recursive_mutex_with_fifo_handoff
  import rmwf_pkg::*;
#(
  parameter int unsigned MAX_WAITERS    = DEF_MAX_WAITERS,
  parameter int unsigned THREAD_ID_BITS = DEF_THREAD_ID_BITS,
  parameter int unsigned COUNT_BITS     = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // request / result
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  result,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rmwf_cmd_t cmd;
  logic      recursive_mode;

  // Register file: one bit at word 0; other words read zero and ignore writes.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RECURSIVE_MODE) ?
                  APB_DATA_W'(recursive_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      recursive_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_RECURSIVE_MODE)) begin
      recursive_mode <= pwdata[0];
    end
  end

  // Sequencer: busy covers the execute cycle; done marks the result cycle.
  rmwf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Owner, hold count, wait queue and the result register.
  rmwf_dp #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req            (req),
    .recursive_mode (recursive_mode),
    .result         (result)
  );

endmodule

FILE: dv/recursive_mutex_with_fifo_handoff_tb.sv
// Self-checking testbench for the recursive mutex unit with FIFO wait-queue handoff.
`timescale 1ns / 100ps

module recursive_mutex_with_fifo_handoff_tb;
  import rmwf_pkg::*;

  localparam int unsigned WAIT_DEPTH  = DEF_MAX_WAITERS;
  localparam int unsigned NUM_DIR     = 23;
  localparam int unsigned RAND_ITEMS  = 1000;
  localparam int unsigned SEG_ITEMS   = 250;    // recursive_mode flips per segment
  localparam int unsigned NEST_LOCKS  = 40;     // deep nest before the mode is cleared
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // ids reused often so that owner, waiter and requester collide
  localparam logic [7:0] HOT_IDS [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5,
                                         8'h01, 8'h80, 8'h7F, 8'h3C};

  // one row of the directed table: a register write or a request, with the
  // result typed in where it is obvious, else left to the predictor
  typedef struct packed {
    logic wr_cfg;
    logic mode;
    logic typed;
    req_t rq;
    rsp_t rsp;
  } dir_row_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  start   = 1'b0;
  logic                  busy;
  req_t                  req     = '0;
  logic                  done;
  rsp_t                  result;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor copy of the mutex
  logic        rec_mode  = 1'b0;
  logic        mtx_held  = 1'b0;
  logic [7:0]  mtx_owner = '0;
  logic [15:0] mtx_count = '0;
  logic [7:0]  waiters [$];

  rsp_t        pending_rsp [$];   // results owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  dir_row_t    dir_tab [NUM_DIR];

  recursive_mutex_with_fifo_handoff dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Apply one request to the predictor copy and return the result it owes.
  function automatic rsp_t mutex_next(input req_t r);
    rsp_t       o;
    logic       woke;
    logic [7:0] woken;
    o     = '0;
    woke  = 1'b0;
    woken = '0;
    o.status = ST_OK;
    case (r.func)
      FUNC_LOCK: begin
        if (!mtx_held) begin
          mtx_held  = 1'b1;
          mtx_owner = r.thread_id;
          mtx_count = 16'd1;
        end else if (mtx_owner == r.thread_id) begin
          // re-lock nests only in recursive mode, and stops at all ones
          if (rec_mode && mtx_count != '1) mtx_count = mtx_count + 16'd1;
        end else if (waiters.size() >= WAIT_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          waiters.push_back(r.thread_id);
          o.status = ST_BLOCKED;
        end
      end
      FUNC_TRY_LOCK: begin
        if (!mtx_held) begin
          mtx_held  = 1'b1;
          mtx_owner = r.thread_id;
          mtx_count = 16'd1;
        end else begin
          o.status = ST_REFUSED;
        end
      end
      FUNC_UNLOCK: begin
        if (!mtx_held || mtx_owner != r.thread_id) begin
          o.status = ST_NOT_OWNER;
        end else begin
          if (mtx_count != 0) mtx_count = mtx_count - 16'd1;
          // with the mode off, any owner unlock is final even if still nested
          if (!(rec_mode && mtx_count != 0)) begin
            if (waiters.size() == 0) begin
              mtx_held  = 1'b0;
              mtx_owner = '0;
              mtx_count = '0;
            end else begin
              woken     = waiters.pop_front();
              mtx_owner = woken;
              mtx_count = 16'd1;
              woke      = 1'b1;
            end
          end
        end
      end
      default: ;  // unused code: no change, status ok
    endcase
    o.owner_valid  = mtx_held;
    o.owner_thread = mtx_held ? mtx_owner : 8'h00;
    o.hold_count   = mtx_held ? mtx_count : 16'd0;
    o.wake_valid   = woke;
    o.wake_thread  = woken;
    return o;
  endfunction

  function automatic string rsp_str(input rsp_t r);
    return $sformatf("status=%0d owner=%0b/%02h count=%0d wake=%0b/%02h",
                     r.status, r.owner_valid, r.owner_thread, r.hold_count,
                     r.wake_valid, r.wake_thread);
  endfunction

  function automatic logic [7:0] pick_thread();
    if ($urandom_range(99) < 60) return HOT_IDS[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  task automatic note_mismatch(input string what, input string want, input string got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected %s, got %s", $realtime, what, want, got);
  endtask

  // Result monitor: done marks a one-cycle result that cannot be held off.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected result", "none", rsp_str(result));
      end else begin
        want = pending_rsp.pop_front();
        if (result.status       !== want.status       ||
            result.owner_valid  !== want.owner_valid  ||
            result.owner_thread !== want.owner_thread ||
            result.hold_count   !== want.hold_count   ||
            result.wake_valid   !== want.wake_valid   ||
            result.wake_thread  !== want.wake_thread)
          note_mismatch("result", rsp_str(want), rsp_str(result));
      end
    end
  end

  // Drive one request and hold it until the block takes it. start is left
  // high so a back-to-back transaction needs no second assignment this step.
  task automatic issue_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t p;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    p = mutex_next(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
  endtask

  task automatic pause_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Register write then read-back, only with the block idle.
  task automatic set_recursive_mode(input logic mode);
    wait_all_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({REG_RECURSIVE_MODE, 2'b00});
    pwdata  <= APB_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rec_mode = mode;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[0] !== mode)
      note_mismatch("recursive_mode read-back", $sformatf("%0b", mode),
                    $sformatf("%0b", prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    int unsigned roll;
    int unsigned lock_pct;
    logic [1:0]  fn;
    logic [7:0]  tid;

    dir_tab = '{
      // free mutex: unlock refused, unused code ignored
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'h00},
        rsp_t'{ST_NOT_OWNER, 1'b0, 8'h00, 16'd0, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNUSED, 8'hFF},
        rsp_t'{ST_OK, 1'b0, 8'h00, 16'd0, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_TRY_LOCK, 8'hFF},
        rsp_t'{ST_OK, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      // owner re-lock without recursive mode changes nothing
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_LOCK, 8'hFF},
        rsp_t'{ST_OK, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_TRY_LOCK, 8'hFF},
        rsp_t'{ST_REFUSED, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_LOCK, 8'h00},
        rsp_t'{ST_BLOCKED, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      // a waiting thread locking again is queued twice
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_LOCK, 8'h00}, '0},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_TRY_LOCK, 8'h00},
        rsp_t'{ST_REFUSED, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'h00},
        rsp_t'{ST_NOT_OWNER, 1'b1, 8'hFF, 16'd1, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'hFF},
        rsp_t'{ST_OK, 1'b1, 8'h00, 16'd1, 1'b1, 8'h00}},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_UNLOCK, 8'h00}, '0},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'h00},
        rsp_t'{ST_OK, 1'b0, 8'h00, 16'd0, 1'b0, 8'h00}},
      // recursive mode: nesting, try by owner, waiter behind a nested hold
      '{1'b1, 1'b1, 1'b0, '0, '0},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_LOCK, 8'h5A},
        rsp_t'{ST_OK, 1'b1, 8'h5A, 16'd1, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_LOCK, 8'h5A}, '0},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_TRY_LOCK, 8'h5A}, '0},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_LOCK, 8'hA5}, '0},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_UNLOCK, 8'h5A}, '0},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_LOCK, 8'h5A}, '0},
      // mode cleared under a nested hold: next unlock is final, hands off
      '{1'b1, 1'b0, 1'b0, '0, '0},
      '{1'b0, 1'b0, 1'b0, req_t'{FUNC_UNLOCK, 8'h5A}, '0},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'hA5},
        rsp_t'{ST_OK, 1'b0, 8'h00, 16'd0, 1'b0, 8'h00}},
      '{1'b0, 1'b0, 1'b1, req_t'{FUNC_UNLOCK, 8'hA5},
        rsp_t'{ST_NOT_OWNER, 1'b0, 8'h00, 16'd0, 1'b0, 8'h00}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_tab[i].wr_cfg) set_recursive_mode(dir_tab[i].mode);
      else issue_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rsp);
    end

    // Fill the wait queue to the brim, overflow it once, then drain it by
    // handing ownership down the chain.
    issue_request(req_t'{FUNC_LOCK, 8'h01}, 1'b0, '0);
    for (int i = 0; i <= WAIT_DEPTH; i++)
      issue_request(req_t'{FUNC_LOCK, 8'(8'h80 + i)}, 1'b0, '0);
    for (int i = 0; i <= WAIT_DEPTH; i++)
      issue_request(req_t'{FUNC_UNLOCK, mtx_owner}, 1'b0, '0);

    // Random traffic. Mostly well-formed: unlocks come from the owner, ids
    // come from a small hot set so that re-locks and queueing happen often.
    // Lock-heavy and unlock-heavy stretches are picked at random to sweep queue depth.
    lock_pct = 34;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % SEG_ITEMS == 0) set_recursive_mode(1'((n / SEG_ITEMS) % 2));
      if (n == 625) wait_all_results();
      if (n % 50 == 0) lock_pct = ($urandom_range(1) == 1) ? 66 : 34;
      // no sender gaps in the middle stretch
      if ((n < 300 || n >= 600) && $urandom_range(99) < 6)
        pause_sender($urandom_range(1, 5));
      roll = $urandom_range(99);
      if (roll < 4) begin
        fn  = FUNC_UNUSED;
        tid = 8'($urandom_range(255));
      end else if (roll < 4 + lock_pct) begin
        fn  = FUNC_LOCK;
        tid = (mtx_held && $urandom_range(99) < 15) ? mtx_owner : pick_thread();
      end else if (roll < 14 + lock_pct) begin
        fn  = FUNC_TRY_LOCK;
        tid = pick_thread();
      end else begin
        fn  = FUNC_UNLOCK;
        tid = ($urandom_range(99) < 80) ? mtx_owner : pick_thread();
      end
      issue_request(req_t'{fn, tid}, 1'b0, '0);
    end

    // Nest the hold count deeply, park a waiter, then clear the mode so
    // that one unlock from the nested owner hands off.
    set_recursive_mode(1'b1);
    while (mtx_held) issue_request(req_t'{FUNC_UNLOCK, mtx_owner}, 1'b0, '0);
    for (int i = 0; i < NEST_LOCKS; i++)
      issue_request(req_t'{FUNC_LOCK, 8'h3C}, 1'b0, '0);
    issue_request(req_t'{FUNC_LOCK, 8'hC3}, 1'b0, '0);
    set_recursive_mode(1'b0);
    issue_request(req_t'{FUNC_UNLOCK, 8'h3C}, 1'b0, '0);
    issue_request(req_t'{FUNC_UNLOCK, 8'hC3}, 1'b0, '0);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rmwf_pkg.sv
hdl/rmwf_ctrl.sv
hdl/rmwf_dp.sv
hdl/recursive_mutex_with_fifo_handoff.sv
dv/recursive_mutex_with_fifo_handoff_tb.sv
